>>> hdl/positional_list_engine_defines.svh
// Shared assertion macros for the positional list engine checkers.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define PLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("list engine check failed");

// Check a consequence in the cycle after its cause.
`define PLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("list engine check failed");

`endif

>>> hdl/ple_pkg.sv
`default_nettype none

package ple_pkg;

    localparam int DATA_W    = 64;
    localparam int OP_W      = 3;
    localparam int POS_W     = 5;
    localparam int COUNT_W   = 5;
    // Wide enough for any list index up to the largest supported depth
    localparam int CMD_IDX_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_AT   = 3'd1,
        OP_INS_END  = 3'd2,
        OP_DEL_HEAD = 3'd3,
        OP_DEL_AT   = 3'd4,
        OP_DEL_END  = 3'd5
    } t_op;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic                 ins;
        logic                 del;
        logic [CMD_IDX_W-1:0] idx;
    } t_cmd;

endpackage

`default_nettype wire

>>> hdl/ple_cell.sv
`default_nettype none

module ple_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                      i_clk,
    input  wire ple_pkg::t_cmd             i_cmd,
    input  wire logic [ple_pkg::DATA_W-1:0] i_value,
    input  wire logic [ple_pkg::DATA_W-1:0] i_left,
    input  wire logic [ple_pkg::DATA_W-1:0] i_right,
    input  wire logic [ple_pkg::DATA_W-1:0] i_pick,
    output logic      [ple_pkg::DATA_W-1:0] o_data,
    output logic      [ple_pkg::DATA_W-1:0] o_pick
);
    import ple_pkg::*;

    localparam logic [CMD_IDX_W-1:0] MY_IDX = CMD_IDX_W'(INDEX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              hit;

    assign hit = (i_cmd.idx == MY_IDX);

    // Take the left neighbor or the new word on insert, the right neighbor on delete
    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (MY_IDX > i_cmd.idx) begin
                n_data = i_left;
            end else if (hit) begin
                n_data = i_value;
            end
        end else if (i_cmd.del) begin
            if (MY_IDX >= i_cmd.idx) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Pass the removed word along the row
    assign o_pick = (i_cmd.del && hit) ? (i_pick | r_data) : i_pick;
    assign o_data = r_data;

endmodule

`default_nettype wire

>>> hdl/positional_list_engine.sv
// positional_list_engine: bounded ordered list of 64-bit words, DEPTH entries.
// Input channel (i_in_valid / o_in_stall) carries one request: an op code,
// a list position and a word. Ops insert at head, at a position or at the
// end, or delete from head, at a position or from the end. An insert
// position at or past the count appends; a delete position past the end
// takes the last entry.
// Output channel (o_out_valid / i_out_stall) returns one result per request:
// the removed word (zero for inserts, unused ops and an empty list), the
// empty and full flags and the entry count after the request.
// The result is registered and shows in the cycle after the request is accepted.
// Throughput: one request per cycle while no result is stalled; a row of DEPTH cells
// shifts the entries from the index onward left or right together in that cycle.
// Reset clears the count and the result valid flag; entry storage is not
// cleared. While the receiver stalls a waiting result, it holds and the
// input channel stalls too.
`default_nettype none

module positional_list_engine #(
    parameter int DEPTH = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [ple_pkg::OP_W-1:0]    i_op,
    input  wire logic [ple_pkg::POS_W-1:0]   i_position,
    input  wire logic [ple_pkg::DATA_W-1:0]  i_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [ple_pkg::DATA_W-1:0]  o_removed_value,
    output logic                             o_was_empty,
    output logic                             o_was_full,
    output logic      [ple_pkg::COUNT_W-1:0] o_entry_count
);
    import ple_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic [IW-1:0] pos_e;
    logic [IW-1:0] cnt_e;
    logic [IW-1:0] last_e;
    logic [IW-1:0] idx;
    logic          do_ins;
    logic          do_del;
    logic          flag_full;
    logic          flag_empty;
    t_cmd          cmd;

    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] pick      [DEPTH+1];

    logic                r_out_valid;
    logic [DATA_W-1:0]   r_removed;
    logic                r_empty;
    logic                r_full;
    logic [CW-1:0]       r_res_count;
    logic [IW-1:0]       res_count_e;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign is_full  = (r_count >= CW'(DEPTH));
    assign is_empty = (r_count == '0);
    assign pos_e    = IW'(i_position);
    assign cnt_e    = IW'(r_count);
    assign last_e   = cnt_e - IW'(1);

    // Decode the op into a clamped index and a shift direction
    always_comb begin
        idx        = '0;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        flag_full  = 1'b0;
        flag_empty = 1'b0;
        unique case (t_op'(i_op))
            OP_INS_HEAD: begin
                idx       = '0;
                do_ins    = !is_full;
                flag_full = is_full;
            end
            OP_INS_AT: begin
                idx       = (pos_e > cnt_e) ? cnt_e : pos_e;
                do_ins    = !is_full;
                flag_full = is_full;
            end
            OP_INS_END: begin
                idx       = cnt_e;
                do_ins    = !is_full;
                flag_full = is_full;
            end
            OP_DEL_HEAD: begin
                idx        = '0;
                do_del     = !is_empty;
                flag_empty = is_empty;
            end
            OP_DEL_AT: begin
                idx        = (pos_e >= cnt_e) ? last_e : pos_e;
                do_del     = !is_empty;
                flag_empty = is_empty;
            end
            OP_DEL_END: begin
                idx        = last_e;
                do_del     = !is_empty;
                flag_empty = is_empty;
            end
            default: begin
                idx = '0;
            end
        endcase
    end

    assign cmd.ins = accept && do_ins;
    assign cmd.del = accept && do_del;
    assign cmd.idx = CMD_IDX_W'(idx);

    // Row of storage cells
    assign pick[0] = '0;
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ple_cell #(
            .INDEX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (cmd),
            .i_value(i_value),
            .i_left ((g == 0) ? i_value : cell_data[(g == 0) ? 0 : g - 1]),
            .i_right((g == DEPTH - 1) ? cell_data[g] : cell_data[(g == DEPTH - 1) ? g : g + 1]),
            .i_pick (pick[g]),
            .o_data (cell_data[g]),
            .o_pick (pick[g+1])
        );
    end

    // Advance the count
    always_comb begin
        n_count = r_count;
        if (cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (cmd.del) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_removed   <= pick[DEPTH];
            r_empty     <= flag_empty;
            r_full      <= flag_full;
            r_res_count <= n_count;
        end
    end

    assign res_count_e     = IW'(r_res_count);
    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_removed;
    assign o_was_empty     = r_empty;
    assign o_was_full      = r_full;
    assign o_entry_count   = res_count_e[COUNT_W-1:0];

endmodule

`default_nettype wire

>>> hdl/ple_checker.sv
`default_nettype none

`include "positional_list_engine_defines.svh"

module ple_checker #(
    parameter int DEPTH = 16
) (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [ple_pkg::DATA_W-1:0]  o_removed_value,
    input wire logic                        o_was_empty,
    input wire logic                        o_was_full,
    input wire logic [ple_pkg::COUNT_W-1:0] o_entry_count
);
    import ple_pkg::*;

    // The input stalls only behind a stalled result
    `PLE_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // A result never reports both an empty and a full list
    `PLE_ASSERT_NOW(a_flags_exclusive, o_out_valid, !(o_was_empty && o_was_full))

    // A delete on an empty list removes nothing and leaves it empty
    `PLE_ASSERT_NOW(a_empty_result, o_out_valid && o_was_empty, o_removed_value == '0 && o_entry_count == '0)

    // A dropped insert removes nothing and leaves the list full
    `PLE_ASSERT_NOW(a_full_result, o_out_valid && o_was_full, o_removed_value == '0 && o_entry_count == COUNT_W'(DEPTH))

    // A stalled result stays put
    `PLE_ASSERT_NEXT(a_result_holds, o_out_valid && i_out_stall, o_out_valid && $stable(o_removed_value) && $stable(o_entry_count))

endmodule

bind positional_list_engine ple_checker #(.DEPTH(DEPTH)) u_ple_checker (.*);

`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int LIST_DEPTH       = 16;
    localparam int RANDOM_PER_PHASE = 642;
    localparam int FLIP_EVERY       = 32;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES     = 4;

    // Op codes the block leaves without effect
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0]  removed_value;
        logic               was_empty;
        logic               was_full;
        logic [COUNT_W-1:0] entry_count;
    } t_list_result;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
        bit                has_typed;
        t_list_result      typed;
    } t_stim_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [OP_W-1:0]      i_op        = '0;
    logic [POS_W-1:0]     i_position  = '0;
    logic [DATA_W-1:0]    i_value     = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [DATA_W-1:0]    o_removed_value;
    logic                 o_was_empty;
    logic                 o_was_full;
    logic [COUNT_W-1:0]   o_entry_count;

    // Predictor state: the words held, head first
    logic [DATA_W-1:0] held_words[$];
    t_list_result      pending_results[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  long_hold_req  = 1'b0;
    int  hold_left      = 0;
    int  mismatch_count = 0;
    int  request_count  = 0;
    int  result_count   = 0;
    int  full_drops     = 0;
    int  empty_deletes  = 0;
    int  clamped_deletes = 0;

    positional_list_engine #(
        .DEPTH(LIST_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_position     (i_position),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_removed_value(o_removed_value),
        .o_was_empty    (o_was_empty),
        .o_was_full     (o_was_full),
        .o_entry_count  (o_entry_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Apply one request to the predicted list and return its result
    function automatic t_list_result apply_request(input logic [OP_W-1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [DATA_W-1:0] word);
        t_list_result res;
        int           idx;
        bit           is_insert;
        bit           is_delete;
        res       = '0;
        idx       = 0;
        is_insert = 1'b0;
        is_delete = 1'b0;
        case (op)
            OP_INS_HEAD: begin is_insert = 1'b1; idx = 0; end
            OP_INS_AT:   begin is_insert = 1'b1; idx = int'(pos); end
            OP_INS_END:  begin is_insert = 1'b1; idx = held_words.size(); end
            OP_DEL_HEAD: begin is_delete = 1'b1; idx = 0; end
            OP_DEL_AT:   begin is_delete = 1'b1; idx = int'(pos); end
            OP_DEL_END:  begin is_delete = 1'b1; idx = held_words.size() - 1; end
            default: ;
        endcase
        if (is_insert) begin
            if (held_words.size() >= LIST_DEPTH) begin
                res.was_full = 1'b1;
                full_drops++;
            end else begin
                // append when the index is past the end
                if (idx > held_words.size()) idx = held_words.size();
                held_words.insert(idx, word);
            end
        end else if (is_delete) begin
            if (held_words.size() == 0) begin
                res.was_empty = 1'b1;
                empty_deletes++;
            end else begin
                // clamp to the last entry
                if (idx >= held_words.size()) begin
                    if (op == OP_DEL_AT) clamped_deletes++;
                    idx = held_words.size() - 1;
                end
                res.removed_value = held_words[idx];
                held_words.delete(idx);
            end
        end
        res.entry_count = COUNT_W'(held_words.size());
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
                 result_count, field, got, want);
        mismatch_count++;
    endtask

    // Compare one accepted result against the oldest expectation
    task automatic check_result();
        t_list_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("unrequested result", o_removed_value, '0);
        end else begin
            want = pending_results.pop_front();
            if (o_removed_value !== want.removed_value)
                report_mismatch("removed_value", o_removed_value, want.removed_value);
            if (o_was_empty !== want.was_empty)
                report_mismatch("was_empty", DATA_W'(o_was_empty), DATA_W'(want.was_empty));
            if (o_was_full !== want.was_full)
                report_mismatch("was_full", DATA_W'(o_was_full), DATA_W'(want.was_full));
            if (o_entry_count !== want.entry_count)
                report_mismatch("entry_count", DATA_W'(o_entry_count),
                                DATA_W'(want.entry_count));
        end
        result_count++;
    endtask

    // Receiver: take results, stall at random or for a long hold
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) check_result();
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Offer one request, wait for acceptance, record what it should return
    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] word, input bit has_typed,
                                input t_list_result typed);
        t_list_result predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_position <= pos;
        i_value    <= word;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = apply_request(op, pos, word);
        pending_results.push_back(has_typed ? typed : predicted);
        request_count++;
    endtask

    function automatic void add_row(ref t_stim_row rows[$], input logic [OP_W-1:0] op,
                                    input logic [POS_W-1:0] pos,
                                    input logic [DATA_W-1:0] word, input bit has_typed,
                                    input t_list_result typed);
        t_stim_row row;
        row.op        = op;
        row.position  = pos;
        row.value     = word;
        row.has_typed = has_typed;
        row.typed     = typed;
        rows.push_back(row);
    endfunction

    // Pick an op, leaning toward inserts while growing, deletes while shrinking
    function automatic logic [OP_W-1:0] pick_op(input bit grow);
        int r;
        int which;
        bit insert_op;
        r     = $urandom_range(0, 99);
        which = $urandom_range(0, 2);
        if (r < 3) return r[0] ? OP_SPARE_6 : OP_SPARE_7;
        insert_op = grow ? (r < 75) : (r < 28);
        case (which)
            0:       return insert_op ? OP_INS_HEAD : OP_DEL_HEAD;
            1:       return insert_op ? OP_INS_AT   : OP_DEL_AT;
            default: return insert_op ? OP_INS_END  : OP_DEL_END;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    initial begin
        t_stim_row         rows[$];
        t_list_result      none;
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        int                k;
        int                phase;
        none = '0;

        // Empty list: deletes report empty, spare op reports nothing
        add_row(rows, OP_DEL_HEAD, 5'd0,  '1, 1'b1, '{'0, 1'b1, 1'b0, 5'd0});
        add_row(rows, OP_DEL_AT,   5'd31, '0, 1'b1, '{'0, 1'b1, 1'b0, 5'd0});
        add_row(rows, OP_DEL_END,  5'd16, '0, 1'b1, '{'0, 1'b1, 1'b0, 5'd0});
        add_row(rows, OP_SPARE_6,  5'd31, '1, 1'b1, '{'0, 1'b0, 1'b0, 5'd0});
        // Insert past the end appends, then the other insert flavors
        add_row(rows, OP_INS_AT,   5'd31, '1, 1'b0, none);
        add_row(rows, OP_INS_HEAD, 5'd0,  '0, 1'b0, none);
        add_row(rows, OP_INS_END,  5'd0,  64'h8000_0000_0000_0001, 1'b0, none);
        add_row(rows, OP_INS_AT,   5'd1,  64'h0123_4567_89ab_cdef, 1'b0, none);
        // Fill the list to capacity
        for (k = 0; k < LIST_DEPTH - 4; k++)
            add_row(rows, (k % 3 == 0) ? OP_INS_HEAD : (k % 3 == 1) ? OP_INS_AT : OP_INS_END,
                    POS_W'($urandom_range(0, 16)), {$urandom, $urandom}, 1'b0, none);
        // Full list drops the insert; then clamped, head and end deletes and a spare op
        add_row(rows, OP_INS_HEAD, 5'd0,  '1, 1'b1, '{'0, 1'b0, 1'b1, 5'd16});
        add_row(rows, OP_DEL_AT,   5'd31, '0, 1'b0, none);
        add_row(rows, OP_DEL_HEAD, 5'd0,  '0, 1'b0, none);
        add_row(rows, OP_DEL_END,  5'd0,  '0, 1'b0, none);
        add_row(rows, OP_SPARE_7,  5'd16, '1, 1'b0, none);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table back to back
        foreach (rows[i])
            send_request(rows[i].op, rows[i].position, rows[i].value,
                         rows[i].has_typed, rows[i].typed);

        // Random requests in three pacing phases
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 62;
                end
                1: begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 33;
                    // hold results back while requests keep coming
                    long_hold_req  = 1'b1;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    // pause until every result is back
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
            endcase
            for (k = 0; k < RANDOM_PER_PHASE; k++) begin
                op = pick_op(((k / FLIP_EVERY) % 2) == 0);
                if ($urandom_range(0, 3) == 0)
                    pos = POS_W'($urandom_range(0, 31));
                else
                    pos = POS_W'($urandom_range(0, held_words.size() + 1));
                send_request(op, pos, pick_word(), 1'b0, none);
            end
        end

        // Drain outstanding results
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests and checked %0d results under three pacing mixes.",
                 request_count, result_count);
        $display("Saw %0d full-list drops, %0d empty-list deletes, %0d clamped deletes.",
                 full_drops, empty_deletes, clamped_deletes);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine.sv
hdl/ple_checker.sv
tb/sv/tb.sv
